@@ sv/mmi_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the modular matrix inverse block.
// No dependencies; every other file but mmi_ram refers to it by scoped names.
package mmi_pkg;

	localparam int WORD_W = 31;
	localparam int SIZE_W = 7;
	localparam logic [WORD_W-1:0] DEFAULT_MOD = 31'd1000000007;
	localparam logic [WORD_W-1:0] MIN_MOD = 31'd3;
	localparam logic [WORD_W-1:0] WORD_ONE = 31'd1;
	localparam logic [WORD_W-1:0] WORD_ZERO = 31'd0;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd1;

	// Operation codes of an input word.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_SIZE = 1'b0;
	localparam logic CFG_MOD = 1'b1;

	typedef struct packed {
		logic              op;
		logic [WORD_W-1:0] element_value;
	} in_word_t;

	typedef struct packed {
		logic [WORD_W-1:0] inverse_value;
		logic              is_last;
		logic              singular;
	} out_word_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_LD_WAIT, ST_RD_OUT, ST_INIT,
		ST_SRCH_RD, ST_SRCH_CHK,
		ST_SW0, ST_SW1, ST_SW2, ST_SW3,
		ST_PIV_RD, ST_PIV_LAT, ST_POW_CHK, ST_POW_MA, ST_POW_SQ,
		ST_SC0, ST_SC1, ST_SC2, ST_SC3,
		ST_ELC_RD, ST_ELC_LAT, ST_BK_RD, ST_BK_LAT,
		ST_R0, ST_R1, ST_R2, ST_R3, ST_R4,
		ST_DONE
	} state_t;

	// Modular subtraction of two reduced values.
	function automatic logic [WORD_W-1:0] sub_mod(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] p);
		logic [WORD_W:0] d;
		d = {1'b0, a} - {1'b0, b};
		if (a < b) begin
			d = d + {1'b0, p};
		end
		return d[WORD_W-1:0];
	endfunction

endpackage

@@ sv/mmi_mulmod.sv @@
`timescale 1ns / 1ps
// Bit-serial modular multiplier: one multiplier bit per cycle.
// Depends on mmi_pkg for the word width.
module mmi_mulmod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mmi_pkg::WORD_W-1:0] x,
	input  logic [mmi_pkg::WORD_W-1:0] y,
	input  logic [mmi_pkg::WORD_W-1:0] p,
	output logic                       done,
	output logic [mmi_pkg::WORD_W-1:0] result
);
	localparam int W = mmi_pkg::WORD_W;
	localparam int CNT_W = $clog2(W);

	logic [W-1:0] acc_q, x_q, y_q, p_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [W:0] dbl, dbl_r, sum, sum_r;

	// One step: acc = 2*acc + bit*x, each add followed by one reduction.
	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, p_q}) ? dbl - {1'b0, p_q} : dbl;
		sum = dbl_r + (y_q[W-1] ? {1'b0, x_q} : '0);
		sum_r = (sum >= {1'b0, p_q}) ? sum - {1'b0, p_q} : sum;
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operands and accumulator.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q <= x;
			y_q <= y;
			p_q <= p;
		end else if (busy_q) begin
			acc_q <= sum_r[W-1:0];
			y_q <= {y_q[W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign result = acc_q;
endmodule

@@ sv/mmi_ram.sv @@
`timescale 1ns / 1ps
// Single-port memory with registered read data held between reads.
// No dependencies.
module mmi_ram #(
	parameter int DEPTH = 4096,
	parameter int AW = 12,
	parameter int W = 31
) (
	input  logic          clk,
	input  logic [AW-1:0] addr,
	input  logic          we,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ sv/modular_matrix_inverse.sv @@
`timescale 1ns / 1ps
// Gauss-Jordan inverse modulo a prime, built on one bit-serial modular multiplier.
// Each load word is reduced modulo p in the multiplier. After the last load, elimination
// runs on that multiplier, and the exponentiation inverts the pivot of each column.
// Reset clears counters and flags and loads the default size and modulus; the memories are not
// cleared, and inverse entries never written read as zero through a fill mark.
module modular_matrix_inverse #(
	parameter int MAX_DIM = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  mmi_pkg::in_word_t          in_word,
	output logic                       out_valid,
	input  logic                       out_ready,
	output mmi_pkg::out_word_t         out_word,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [mmi_pkg::WORD_W-1:0] cfg_data
);
	localparam int W = mmi_pkg::WORD_W;
	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = 2 * DW + 1;

	mmi_pkg::state_t state_q, state_d;

	logic [mmi_pkg::SIZE_W-1:0] size_q;
	logic [W-1:0] p_q, p_use;
	logic [DW-1:0] n_use, nm1, i_q, j_q, k_q, piv_q;
	logic [CW-1:0] total, load_count_q, ld_next, rc_q, idx, rc_next, fill_q;
	logic rd_last, singular_q, both_q;
	logic [W-1:0] acc_q, base_q, exp_q, c_q, src_coef_q, src_inv_q;
	logic rd_last_q, rd_zero_q, rd_sing_q;
	logic out_valid_q;
	mmi_pkg::out_word_t out_word_q;
	logic k_last, j_last, i_last, n_gt1;
	logic [2*DW-1:0] total_wide;

	// Memory and multiplier controls.
	logic [DW-1:0] row, col;
	logic [XW-1:0] addr_wide;
	logic [AW-1:0] addr, dir_addr;
	logic dir, re, cwe, iwe;
	logic [W-1:0] cwd, iwd, coef_rd, inv_rd;
	logic mul_start, mul_done;
	logic [W-1:0] mul_x, mul_y, mul_res;
	mmi_pkg::state_t next_col_st;
	logic accept;

	// Size and modulus in use.
	always_comb begin
		if (size_q == '0) begin
			n_use = DW'(1);
		end else if (int'(size_q) > MAX_DIM) begin
			n_use = DW'(MAX_DIM);
		end else begin
			n_use = DW'(size_q);
		end
		p_use = (p_q < mmi_pkg::MIN_MOD) ? mmi_pkg::MIN_MOD : p_q;
		nm1 = n_use - 1'b1;
		total_wide = (2*DW)'(n_use) * (2*DW)'(n_use);
		total = CW'(total_wide);
		k_last = (k_q == nm1);
		j_last = (j_q == nm1);
		i_last = (i_q == nm1);
		n_gt1 = (n_use != DW'(1));
		next_col_st = !i_last ? mmi_pkg::ST_SRCH_RD :
			(n_gt1 ? mmi_pkg::ST_BK_RD : mmi_pkg::ST_DONE);
	end

	// Load and read counters.
	always_comb begin
		ld_next = load_count_q + 1'b1;
		idx = (rc_q >= total) ? '0 : rc_q;
		rd_last = (idx == total - 1'b1);
		rc_next = rd_last ? '0 : idx + 1'b1;
	end

	assign in_ready = (state_q == mmi_pkg::ST_IDLE) && (!out_valid_q || out_ready);
	assign accept = in_valid && in_ready;

	// Next state, memory access and multiplier operands.
	always_comb begin
		state_d = state_q;
		mul_start = 1'b0;
		mul_x = acc_q;
		mul_y = base_q;
		row = i_q;
		col = k_q;
		dir = 1'b0;
		dir_addr = load_count_q[AW-1:0];
		re = 1'b0;
		cwe = 1'b0;
		iwe = 1'b0;
		cwd = mul_res;
		iwd = mul_res;
		case (state_q)
			mmi_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_word.op == mmi_pkg::OP_LOAD) begin
						mul_start = 1'b1;
						mul_x = mmi_pkg::WORD_ONE;
						mul_y = in_word.element_value;
						state_d = mmi_pkg::ST_LD_WAIT;
					end else begin
						dir = 1'b1;
						dir_addr = idx[AW-1:0];
						re = 1'b1;
						state_d = mmi_pkg::ST_RD_OUT;
					end
				end
			end
			mmi_pkg::ST_LD_WAIT: begin
				dir = 1'b1;
				if (mul_done) begin
					cwe = 1'b1;
					state_d = (ld_next >= total) ? mmi_pkg::ST_INIT : mmi_pkg::ST_IDLE;
				end
			end
			mmi_pkg::ST_RD_OUT: begin
				state_d = mmi_pkg::ST_IDLE;
			end
			mmi_pkg::ST_INIT: begin
				row = j_q;
				iwe = 1'b1;
				iwd = (j_q == k_q) ? mmi_pkg::WORD_ONE : mmi_pkg::WORD_ZERO;
				if (k_last && j_last) begin
					state_d = mmi_pkg::ST_SRCH_RD;
				end
			end
			mmi_pkg::ST_SRCH_RD: begin
				row = j_q;
				col = i_q;
				re = 1'b1;
				state_d = mmi_pkg::ST_SRCH_CHK;
			end
			mmi_pkg::ST_SRCH_CHK: begin
				if (coef_rd != '0) begin
					state_d = (j_q != i_q) ? mmi_pkg::ST_SW0 : mmi_pkg::ST_PIV_RD;
				end else if (j_last) begin
					state_d = mmi_pkg::ST_DONE;
				end else begin
					state_d = mmi_pkg::ST_SRCH_RD;
				end
			end
			mmi_pkg::ST_SW0: begin
				re = 1'b1;
				state_d = mmi_pkg::ST_SW1;
			end
			mmi_pkg::ST_SW1: begin
				row = piv_q;
				re = 1'b1;
				state_d = mmi_pkg::ST_SW2;
			end
			mmi_pkg::ST_SW2: begin
				cwe = 1'b1;
				iwe = 1'b1;
				cwd = coef_rd;
				iwd = inv_rd;
				state_d = mmi_pkg::ST_SW3;
			end
			mmi_pkg::ST_SW3: begin
				row = piv_q;
				cwe = 1'b1;
				iwe = 1'b1;
				cwd = src_coef_q;
				iwd = src_inv_q;
				state_d = k_last ? mmi_pkg::ST_PIV_RD : mmi_pkg::ST_SW0;
			end
			mmi_pkg::ST_PIV_RD: begin
				col = i_q;
				re = 1'b1;
				state_d = mmi_pkg::ST_PIV_LAT;
			end
			mmi_pkg::ST_PIV_LAT: begin
				state_d = mmi_pkg::ST_POW_CHK;
			end
			mmi_pkg::ST_POW_CHK: begin
				if (exp_q == '0) begin
					state_d = mmi_pkg::ST_SC0;
				end else if (exp_q[0]) begin
					mul_start = 1'b1;
					state_d = mmi_pkg::ST_POW_MA;
				end else begin
					mul_start = 1'b1;
					mul_x = base_q;
					state_d = mmi_pkg::ST_POW_SQ;
				end
			end
			mmi_pkg::ST_POW_MA: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_x = base_q;
					state_d = mmi_pkg::ST_POW_SQ;
				end
			end
			mmi_pkg::ST_POW_SQ: begin
				if (mul_done) begin
					state_d = mmi_pkg::ST_POW_CHK;
				end
			end
			mmi_pkg::ST_SC0: begin
				re = 1'b1;
				state_d = mmi_pkg::ST_SC1;
			end
			mmi_pkg::ST_SC1: begin
				mul_start = 1'b1;
				mul_y = coef_rd;
				state_d = mmi_pkg::ST_SC2;
			end
			mmi_pkg::ST_SC2: begin
				if (mul_done) begin
					cwe = 1'b1;
					mul_start = 1'b1;
					mul_y = inv_rd;
					state_d = mmi_pkg::ST_SC3;
				end
			end
			mmi_pkg::ST_SC3: begin
				if (mul_done) begin
					iwe = 1'b1;
					if (!k_last) begin
						state_d = mmi_pkg::ST_SC0;
					end else if (!i_last) begin
						state_d = mmi_pkg::ST_ELC_RD;
					end else begin
						state_d = next_col_st;
					end
				end
			end
			mmi_pkg::ST_ELC_RD: begin
				row = j_q;
				col = i_q;
				re = 1'b1;
				state_d = mmi_pkg::ST_ELC_LAT;
			end
			mmi_pkg::ST_ELC_LAT: begin
				state_d = mmi_pkg::ST_R0;
			end
			mmi_pkg::ST_BK_RD: begin
				col = j_q;
				re = 1'b1;
				state_d = mmi_pkg::ST_BK_LAT;
			end
			mmi_pkg::ST_BK_LAT: begin
				state_d = mmi_pkg::ST_R0;
			end
			mmi_pkg::ST_R0: begin
				row = both_q ? i_q : j_q;
				re = 1'b1;
				state_d = mmi_pkg::ST_R1;
			end
			mmi_pkg::ST_R1: begin
				row = both_q ? j_q : i_q;
				re = 1'b1;
				state_d = mmi_pkg::ST_R2;
			end
			mmi_pkg::ST_R2: begin
				mul_start = 1'b1;
				mul_x = src_inv_q;
				mul_y = c_q;
				state_d = mmi_pkg::ST_R3;
			end
			mmi_pkg::ST_R3, mmi_pkg::ST_R4: begin
				row = both_q ? j_q : i_q;
				if (mul_done) begin
					if (state_q == mmi_pkg::ST_R3) begin
						iwe = 1'b1;
						iwd = mmi_pkg::sub_mod(inv_rd, mul_res, p_use);
					end else begin
						cwe = 1'b1;
						cwd = mmi_pkg::sub_mod(coef_rd, mul_res, p_use);
					end
					if (state_q == mmi_pkg::ST_R3 && both_q) begin
						mul_start = 1'b1;
						mul_x = src_coef_q;
						mul_y = c_q;
						state_d = mmi_pkg::ST_R4;
					end else if (!k_last) begin
						state_d = mmi_pkg::ST_R0;
					end else if (both_q) begin
						state_d = j_last ? next_col_st : mmi_pkg::ST_ELC_RD;
					end else if (!j_last || i_q != '0) begin
						state_d = mmi_pkg::ST_BK_RD;
					end else begin
						state_d = mmi_pkg::ST_DONE;
					end
				end
			end
			mmi_pkg::ST_DONE: begin
				state_d = mmi_pkg::ST_IDLE;
			end
			default: begin
				state_d = mmi_pkg::ST_IDLE;
			end
		endcase
		addr_wide = XW'(row) * XW'(n_use) + XW'(col);
		addr = dir ? dir_addr : addr_wide[AW-1:0];
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= mmi_pkg::SIZE_RESET;
			p_q <= mmi_pkg::DEFAULT_MOD;
		end else if (cfg_we) begin
			if (cfg_index == mmi_pkg::CFG_SIZE) begin
				size_q <= cfg_data[mmi_pkg::SIZE_W-1:0];
			end else begin
				p_q <= cfg_data;
			end
		end
	end

	// Control counters and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
			rc_q <= '0;
			fill_q <= '0;
			singular_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			piv_q <= '0;
			both_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == mmi_pkg::ST_RD_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				mmi_pkg::ST_IDLE: begin
					if (accept && in_word.op == mmi_pkg::OP_READ) begin
						rc_q <= rc_next;
					end
				end
				mmi_pkg::ST_LD_WAIT: begin
					if (mul_done) begin
						if (ld_next >= total) begin
							load_count_q <= '0;
							rc_q <= '0;
							singular_q <= 1'b0;
							j_q <= '0;
							k_q <= '0;
							if (total > fill_q) begin
								fill_q <= total;
							end
						end else begin
							load_count_q <= ld_next;
						end
					end
				end
				mmi_pkg::ST_INIT: begin
					if (k_last) begin
						k_q <= '0;
						if (j_last) begin
							i_q <= '0;
							j_q <= '0;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				mmi_pkg::ST_SRCH_CHK: begin
					if (coef_rd != '0) begin
						piv_q <= j_q;
						k_q <= '0;
					end else if (j_last) begin
						singular_q <= 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				mmi_pkg::ST_SW3: begin
					k_q <= k_last ? '0 : k_q + 1'b1;
				end
				mmi_pkg::ST_SC3: begin
					if (mul_done) begin
						if (!k_last) begin
							k_q <= k_q + 1'b1;
						end else begin
							k_q <= '0;
							if (!i_last) begin
								j_q <= i_q + 1'b1;
							end else begin
								i_q <= nm1 - 1'b1;
								j_q <= nm1;
							end
						end
					end
				end
				mmi_pkg::ST_ELC_LAT: begin
					both_q <= 1'b1;
				end
				mmi_pkg::ST_BK_LAT: begin
					both_q <= 1'b0;
				end
				mmi_pkg::ST_R3, mmi_pkg::ST_R4: begin
					if (mul_done && !(state_q == mmi_pkg::ST_R3 && both_q)) begin
						if (!k_last) begin
							k_q <= k_q + 1'b1;
						end else begin
							k_q <= '0;
							if (!j_last) begin
								j_q <= j_q + 1'b1;
							end else if (both_q) begin
								if (!i_last) begin
									i_q <= i_q + 1'b1;
									j_q <= i_q + 1'b1;
								end
							end else if (i_q != '0) begin
								i_q <= i_q - 1'b1;
								j_q <= i_q;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers: exponentiation, row factor, saved operands, read word.
	always_ff @(posedge clk) begin
		case (state_q)
			mmi_pkg::ST_IDLE: begin
				rd_last_q <= rd_last;
				rd_sing_q <= singular_q;
				rd_zero_q <= singular_q || (idx >= fill_q);
			end
			mmi_pkg::ST_PIV_LAT: begin
				base_q <= coef_rd;
				acc_q <= mmi_pkg::WORD_ONE;
				exp_q <= p_use - 2'd2;
			end
			mmi_pkg::ST_POW_MA: begin
				if (mul_done) begin
					acc_q <= mul_res;
				end
			end
			mmi_pkg::ST_POW_SQ: begin
				if (mul_done) begin
					base_q <= mul_res;
					exp_q <= {1'b0, exp_q[W-1:1]};
				end
			end
			mmi_pkg::ST_SW1, mmi_pkg::ST_R1: begin
				src_coef_q <= coef_rd;
				src_inv_q <= inv_rd;
			end
			mmi_pkg::ST_ELC_LAT, mmi_pkg::ST_BK_LAT: begin
				c_q <= coef_rd;
			end
			mmi_pkg::ST_RD_OUT: begin
				out_word_q.inverse_value <= rd_zero_q ? mmi_pkg::WORD_ZERO : inv_rd;
				out_word_q.is_last <= rd_last_q;
				out_word_q.singular <= rd_sing_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	mmi_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.p      (p_use),
		.done   (mul_done),
		.result (mul_res)
	);

	mmi_ram #(.DEPTH(DEPTH), .AW(AW), .W(W)) u_coef (
		.clk   (clk),
		.addr  (addr),
		.we    (cwe),
		.wdata (cwd),
		.re    (re),
		.rdata (coef_rd)
	);

	mmi_ram #(.DEPTH(DEPTH), .AW(AW), .W(W)) u_inv (
		.clk   (clk),
		.addr  (addr),
		.we    (iwe),
		.wdata (iwd),
		.re    (re),
		.rdata (inv_rd)
	);
endmodule

@@ sim/modular_matrix_inverse_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for modular_matrix_inverse: directed and random words are
// predicted by a Gauss-Jordan model mod p kept inside the bench. Depends on mmi_pkg.
module modular_matrix_inverse_tb;

	localparam int WORD_W = mmi_pkg::WORD_W;
	localparam int SIZE_W = mmi_pkg::SIZE_W;
	localparam int DIM_MAX = 64;
	localparam int DEPTH = DIM_MAX * DIM_MAX;
	localparam longint CYCLE_LIMIT = 8000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	mmi_pkg::in_word_t in_word;
	logic out_valid;
	logic out_ready;
	mmi_pkg::out_word_t out_word;
	logic cfg_we;
	logic cfg_index;
	logic [WORD_W-1:0] cfg_data;

	modular_matrix_inverse #(.MAX_DIM(DIM_MAX)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Clock with a 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Mirror of the block state for prediction.
	logic [WORD_W-1:0] coef_mem [DEPTH];
	logic [WORD_W-1:0] inv_mem [DEPTH];
	int unsigned loads_seen;
	int unsigned reads_seen;
	bit singular_seen;
	logic [SIZE_W-1:0] size_reg;
	logic [WORD_W-1:0] mod_reg;
	bit elim_running;

	mmi_pkg::out_word_t inverse_words_q[$];
	int errors;
	int gap_pct;
	int stall_pct;
	int hold_cycles;
	longint cycles;

	function automatic int unsigned dim_now();
		if (size_reg == 0) return 1;
		if (size_reg > DIM_MAX) return DIM_MAX;
		return size_reg;
	endfunction

	function automatic longint unsigned mod_now();
		return (mod_reg < mmi_pkg::MIN_MOD) ? longint'(mmi_pkg::MIN_MOD) : longint'(mod_reg);
	endfunction

	function automatic logic [WORD_W-1:0] mulm(input longint unsigned x,
			input longint unsigned y, input longint unsigned p);
		return WORD_W'((x * y) % p);
	endfunction

	function automatic logic [WORD_W-1:0] subm(input longint unsigned x,
			input longint unsigned y, input longint unsigned p);
		return WORD_W'((x + p - y) % p);
	endfunction

	function automatic logic [WORD_W-1:0] fermat_inv(input logic [WORD_W-1:0] b,
			input longint unsigned p);
		longint unsigned e;
		logic [WORD_W-1:0] acc;
		logic [WORD_W-1:0] sq;
		e = p - 2;
		acc = mmi_pkg::WORD_ONE;
		sq = b;
		while (e != 0) begin
			if (e[0]) acc = mulm(acc, sq, p);
			sq = mulm(sq, sq, p);
			e = e >> 1;
		end
		return acc;
	endfunction

	// Gauss-Jordan elimination on the mirrored stores.
	function automatic void gauss_jordan(input int n, input longint unsigned p);
		int piv;
		logic [WORD_W-1:0] s;
		logic [WORD_W-1:0] t;
		logic [WORD_W-1:0] c;
		singular_seen = 0;
		for (int i = 0; i < n; i++)
			for (int k = 0; k < n; k++)
				inv_mem[i*n+k] = (i == k) ? mmi_pkg::WORD_ONE : mmi_pkg::WORD_ZERO;
		for (int i = 0; i < n; i++) begin
			piv = n;
			for (int j = i; j < n; j++) begin
				if (coef_mem[j*n+i] != 0) begin
					piv = j;
					break;
				end
			end
			if (piv == n) begin
				singular_seen = 1;
				return;
			end
			if (piv != i) begin
				for (int k = 0; k < n; k++) begin
					t = coef_mem[i*n+k];
					coef_mem[i*n+k] = coef_mem[piv*n+k];
					coef_mem[piv*n+k] = t;
					t = inv_mem[i*n+k];
					inv_mem[i*n+k] = inv_mem[piv*n+k];
					inv_mem[piv*n+k] = t;
				end
			end
			s = fermat_inv(coef_mem[i*n+i], p);
			for (int k = 0; k < n; k++) begin
				coef_mem[i*n+k] = mulm(coef_mem[i*n+k], s, p);
				inv_mem[i*n+k] = mulm(inv_mem[i*n+k], s, p);
			end
			for (int j = i + 1; j < n; j++) begin
				c = coef_mem[j*n+i];
				for (int k = 0; k < n; k++) begin
					inv_mem[j*n+k] = subm(inv_mem[j*n+k], mulm(c, inv_mem[i*n+k], p), p);
					coef_mem[j*n+k] = subm(coef_mem[j*n+k], mulm(c, coef_mem[i*n+k], p), p);
				end
			end
		end
		for (int i = n - 2; i >= 0; i--) begin
			for (int j = i + 1; j < n; j++) begin
				c = coef_mem[i*n+j];
				for (int k = 0; k < n; k++)
					inv_mem[i*n+k] = subm(inv_mem[i*n+k], mulm(c, inv_mem[j*n+k], p), p);
			end
		end
	endfunction

	// Update the mirror for one accepted word and queue any expected result.
	function automatic void predict_word(input mmi_pkg::in_word_t w);
		int unsigned n;
		int unsigned total;
		longint unsigned p;
		mmi_pkg::out_word_t r;
		n = dim_now();
		total = n * n;
		p = mod_now();
		if (w.op == mmi_pkg::OP_LOAD) begin
			coef_mem[loads_seen % DEPTH] = WORD_W'(longint'(w.element_value) % p);
			loads_seen++;
			if (loads_seen >= total) begin
				gauss_jordan(n, p);
				loads_seen = 0;
				reads_seen = 0;
				elim_running = 1;
			end
		end else begin
			if (reads_seen >= total) reads_seen = 0;
			r.inverse_value = singular_seen ? mmi_pkg::WORD_ZERO : inv_mem[reads_seen];
			r.is_last = (reads_seen == total - 1);
			r.singular = singular_seen;
			reads_seen = r.is_last ? 0 : reads_seen + 1;
			inverse_words_q.push_back(r);
			elim_running = 0;
		end
	endfunction

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("** modular_matrix_inverse: FAILED **");
			$finish;
		end
	end

	// Receiver side: long holds on request, random stalls otherwise.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles--;
		end else begin
			out_ready <= ($urandom_range(99) < stall_pct) ? 1'b0 : 1'b1;
		end
	end

	// Check each returned word against the oldest expectation.
	always @(posedge clk) begin
		mmi_pkg::out_word_t e;
		if (arst_n && out_valid && out_ready) begin
			if (inverse_words_q.size() == 0) begin
				$display("%0t unexpected word: expected none actual %h", $time, out_word);
				errors++;
			end else begin
				e = inverse_words_q.pop_front();
				if (out_word.inverse_value !== e.inverse_value) begin
					$display("%0t inverse_value: expected %h actual %h", $time,
						e.inverse_value, out_word.inverse_value);
					errors++;
				end
				if (out_word.is_last !== e.is_last) begin
					$display("%0t is_last: expected %b actual %b", $time,
						e.is_last, out_word.is_last);
					errors++;
				end
				if (out_word.singular !== e.singular) begin
					$display("%0t singular: expected %b actual %b", $time,
						e.singular, out_word.singular);
					errors++;
				end
			end
		end
	end

	// Offer one word and wait until it is taken.
	task automatic send_word(input logic op, input logic [WORD_W-1:0] v);
		mmi_pkg::in_word_t w;
		w.op = op;
		w.element_value = v;
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		predict_word(w);
	endtask

	// Stop sending until all words are back and the block has gone quiet.
	task automatic drain();
		int n;
		in_valid <= 1'b0;
		while (inverse_words_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (elim_running) begin
			n = dim_now();
			repeat (80 * n * n * n + 2500 * n + 500) @(posedge clk);
			elim_running = 0;
		end
	endtask

	task automatic write_reg(input logic idx, input logic [WORD_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == mmi_pkg::CFG_SIZE) size_reg = v[SIZE_W-1:0];
		else mod_reg = v;
	endtask

	task automatic setup(input logic [WORD_W-1:0] sz, input logic [WORD_W-1:0] p);
		drain();
		write_reg(mmi_pkg::CFG_SIZE, sz);
		write_reg(mmi_pkg::CFG_MOD, p);
	endtask

	task automatic read_words(input int k);
		repeat (k) send_word(mmi_pkg::OP_READ, WORD_W'($urandom));
	endtask

	task automatic load_words(input logic [WORD_W-1:0] vals[$]);
		foreach (vals[i]) send_word(mmi_pkg::OP_LOAD, vals[i]);
	endtask

	// Reads straight after reset see a zero inverse.
	task automatic test_reset_reads();
		read_words(2);
	endtask

	// Small hand-picked matrices: inverse, zero pivot, pivot swap, wrap, reduction.
	task automatic test_directed();
		load_words('{31'd5});
		read_words(2);
		load_words('{31'd0});
		read_words(1);
		setup(31'h7FFFFF82, 31'h7FFFFFFF);
		load_words('{31'd0, 31'd1, 31'h7FFFFFFF, 31'h7FFFFFFE});
		read_words(5);
		setup(3, 1000000007);
		load_words('{31'd0, 31'd2, 31'd3, 31'd0, 31'd0, 31'd4, 31'd5, 31'd6, 31'd7});
		read_words(9);
		load_words('{31'd1, 31'd2, 31'd3, 31'd2, 31'd4, 31'd6, 31'd0, 31'd0, 31'd9});
		read_words(2);
		setup(0, 2);
		load_words('{31'd7});
		read_words(1);
		setup(2, 0);
		load_words('{31'd1, 31'd1, 31'd1, 31'd2});
		read_words(4);
		setup(2, 9);
		load_words('{31'd2, 31'd3, 31'd1, 31'd4});
		read_words(4);
	endtask

	// Size at and past the limit, then shrinking and growing it in the middle of a load.
	task automatic test_size_edges();
		setup(127, 1000000007);
		repeat (10) send_word(mmi_pkg::OP_LOAD, WORD_W'($urandom));
		read_words(6);
		drain();
		write_reg(mmi_pkg::CFG_SIZE, 64);
		read_words(6);
		send_word(mmi_pkg::OP_LOAD, WORD_W'($urandom));
		drain();
		write_reg(mmi_pkg::CFG_SIZE, 2);
		send_word(mmi_pkg::OP_LOAD, WORD_W'($urandom));
		read_words(4);
		setup(2, 1000000007);
		repeat (2) send_word(mmi_pkg::OP_LOAD, WORD_W'($urandom));
		drain();
		write_reg(mmi_pkg::CFG_SIZE, 3);
		repeat (7) send_word(mmi_pkg::OP_LOAD, WORD_W'($urandom));
		read_words(9);
	endtask

	// One larger matrix.
	task automatic test_large_matrix();
		setup(8, 2147483647);
		repeat (64) send_word(mmi_pkg::OP_LOAD, WORD_W'($urandom));
		read_words(64);
	endtask

	// The receiver stops for a long stretch while reads keep coming.
	task automatic test_backpressure();
		setup(3, 1000000007);
		repeat (9) send_word(mmi_pkg::OP_LOAD, $urandom_range(1000000006));
		drain();
		hold_cycles = 400;
		read_words(30);
		drain();
	endtask

	// Random matrices under the current idle mix.
	task automatic test_random(input int gap, input int stall, input int words);
		int sent;
		int n;
		int sel;
		logic [WORD_W-1:0] p;
		logic [WORD_W-1:0] v;
		gap_pct = gap;
		stall_pct = stall;
		sent = 0;
		while (sent < words) begin
			sel = $urandom_range(9);
			n = (sel < 2) ? 1 : (sel < 5) ? 2 : (sel < 8) ? 3 : 4;
			case ($urandom_range(7))
				0: p = 3;
				1: p = 7;
				2: p = 31'h7FFFFFFF;
				3: p = $urandom_range(2);
				4: p = 1000;
				default: p = 1000000007;
			endcase
			setup(WORD_W'(n) | (WORD_W'($urandom) << SIZE_W), p);
			for (int i = 0; i < n * n; i++) begin
				case ($urandom_range(9))
					0: v = mmi_pkg::WORD_ZERO;
					1: v = $urandom_range(5);
					default: v = WORD_W'($urandom);
				endcase
				send_word(mmi_pkg::OP_LOAD, v);
				sent++;
				if ($urandom_range(19) == 0) begin
					send_word(mmi_pkg::OP_READ, mmi_pkg::WORD_ZERO);
					sent++;
				end
			end
			sel = n * n + $urandom_range(2);
			read_words(sel);
			sent += sel;
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_word <= '0;
		out_ready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= mmi_pkg::CFG_SIZE;
		cfg_data <= '0;
		errors = 0;
		cycles = 0;
		hold_cycles = 0;
		gap_pct = 0;
		stall_pct = 0;
		loads_seen = 0;
		reads_seen = 0;
		singular_seen = 0;
		elim_running = 0;
		size_reg = mmi_pkg::SIZE_RESET;
		mod_reg = mmi_pkg::DEFAULT_MOD;
		foreach (inv_mem[i]) inv_mem[i] = mmi_pkg::WORD_ZERO;
		foreach (coef_mem[i]) coef_mem[i] = mmi_pkg::WORD_ZERO;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_reads();
		test_directed();
		test_size_edges();
		test_large_matrix();
		test_backpressure();
		test_random(14, 79, 220);
		test_random(79, 14, 220);
		test_random(0, 0, 220);

		drain();
		repeat (200) @(posedge clk);
		if (errors == 0 && inverse_words_q.size() == 0) begin
			$display("** modular_matrix_inverse: PASSED **");
		end else begin
			if (inverse_words_q.size() != 0)
				$display("%0t %0d expected words never arrived", $time, inverse_words_q.size());
			$display("** modular_matrix_inverse: FAILED **");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/mmi_pkg.sv
sv/mmi_mulmod.sv
sv/mmi_ram.sv
sv/modular_matrix_inverse.sv
sim/modular_matrix_inverse_tb.sv
